>>> hdl/sorted_timer_queue_unit_assert.svh
// Assertion macros for the sorted timer queue.
// Each macro takes a label, an antecedent, a consequent and a message.
// Every use expects i_clk and i_rst_n in scope.
`ifndef SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define STQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define STQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define STQ_ASSERT_IMP(lbl, ante, cons, msg)
`define STQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Widths, depth and the command and status groups of the timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DELAY_W     = 16;
    localparam int TAG_W       = 32;
    localparam int TIME_W      = 32;

    // Result kinds
    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic insert;     // shift-insert the accepted alarm
        logic tick;       // advance the time counter
        logic capture;    // hold the accepted word
        logic load_resp;  // put the held word on the output
        logic pop;        // move the head to the output and shift left
    } t_stq_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_action;
        logic in_delay_zero;
        logic full;
        logic head_due;
        logic next_due;
        logic out_free;
    } t_stq_sts;

endpackage

>>> hdl/stq_in_if.sv
// ----------------------------------------------------------------------------
// stq_in_if
// Input channel of the timer queue: a tick or an insert word.
// ----------------------------------------------------------------------------
interface stq_in_if
    import stq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               action;
    logic [DELAY_W-1:0] delay_ticks;
    logic [TAG_W-1:0]   message_tag;

    modport source (output valid, action, delay_ticks, message_tag, input ready);
    modport sink   (input valid, action, delay_ticks, message_tag, output ready);

endinterface

>>> hdl/stq_out_if.sv
// ----------------------------------------------------------------------------
// stq_out_if
// Output channel of the timer queue: expiry and drop words.
// ----------------------------------------------------------------------------
interface stq_out_if
    import stq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [DELAY_W-1:0] echo_delay;
    logic [TAG_W-1:0]   echo_tag;
    logic               last_of_run;

    modport source (output valid, result_kind, echo_delay, echo_tag, last_of_run,
                    input ready);
    modport sink   (input valid, result_kind, echo_delay, echo_tag, last_of_run,
                    output ready);

endinterface

>>> hdl/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer of the timer queue: takes words, issues inserts, ticks, drop or
// zero-delay responses and the expiry run.
// ----------------------------------------------------------------------------
module stq_ctrl
    import stq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_stq_sts i_sts,
    output t_stq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.in_action) begin
                        if (i_sts.in_delay_zero || i_sts.full) begin
                            n_state = S_RESP;
                        end else begin
                            o_cmd.insert = 1'b1;
                        end
                    end else begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_POP;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_resp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_POP: begin
                // drain due entries from the head, one word a cycle while the output is free
                if (!i_sts.head_due) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (!i_sts.next_due) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

>>> hdl/stq_datapath.sv
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted chain of alarm cells, time counter, held input word and output
// register.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_unit_assert.svh"

module stq_datapath
    import stq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_action,
    input  logic [DELAY_W-1:0] i_delay_ticks,
    input  logic [TAG_W-1:0]   i_message_tag,
    input  t_stq_cmd           i_cmd,
    output t_stq_sts           o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_result_kind,
    output logic [DELAY_W-1:0] o_echo_delay,
    output logic [TAG_W-1:0]   o_echo_tag,
    output logic               o_last_of_run
);

    logic [TIME_W-1:0]      r_time;
    logic [QUEUE_DEPTH-1:0] r_valid, n_valid;
    logic [TIME_W-1:0]      r_dl  [QUEUE_DEPTH];
    logic [TIME_W-1:0]      n_dl  [QUEUE_DEPTH];
    logic [DELAY_W-1:0]     r_dly [QUEUE_DEPTH];
    logic [DELAY_W-1:0]     n_dly [QUEUE_DEPTH];
    logic [TAG_W-1:0]       r_tag [QUEUE_DEPTH];
    logic [TAG_W-1:0]       n_tag [QUEUE_DEPTH];

    logic [DELAY_W-1:0]     r_in_delay;
    logic [TAG_W-1:0]       r_in_tag;

    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [DELAY_W-1:0]     r_out_delay;
    logic [TAG_W-1:0]       r_out_tag;
    logic                   r_out_last;

    logic [QUEUE_DEPTH-1:0] hit, hit_prev;
    logic [TIME_W-1:0]      new_dl;
    logic                   head_due, next_due, out_free;

    // A cell is a hit when empty or when its time left is at least the new delay.
    // The chain is sorted by time left, so hits form a suffix.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hit[i] = !r_valid[i] ||
                     ((r_dl[i] - r_time) >= {{(TIME_W-DELAY_W){1'b0}}, i_delay_ticks});
        end
    end

    assign hit_prev = {hit[QUEUE_DEPTH-2:0], 1'b0};
    assign new_dl   = r_time + {{(TIME_W-DELAY_W){1'b0}}, i_delay_ticks};

    assign head_due = r_valid[0] && (r_dl[0] == r_time);
    assign next_due = r_valid[1] && (r_dl[1] == r_time);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        n_dl    = r_dl;
        n_dly   = r_dly;
        n_tag   = r_tag;
        if (i_cmd.insert) begin
            n_valid = r_valid | {r_valid[QUEUE_DEPTH-2:0], 1'b1};
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (hit_prev[i]) begin
                    // cell lies behind the insert point: take the one ahead
                    n_dl[i]  = r_dl[(i == 0) ? 0 : i-1];
                    n_dly[i] = r_dly[(i == 0) ? 0 : i-1];
                    n_tag[i] = r_tag[(i == 0) ? 0 : i-1];
                end else if (hit[i]) begin
                    n_dl[i]  = new_dl;
                    n_dly[i] = i_delay_ticks;
                    n_tag[i] = i_message_tag;
                end
            end
        end else if (i_cmd.pop) begin
            n_valid = {1'b0, r_valid[QUEUE_DEPTH-1:1]};
            for (int i = 0; i < QUEUE_DEPTH-1; i++) begin
                n_dl[i]  = r_dl[i+1];
                n_dly[i] = r_dly[i+1];
                n_tag[i] = r_tag[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.tick) begin
                r_time <= r_time + 1'b1;
            end
            if (i_cmd.load_resp || i_cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl  <= n_dl;
        r_dly <= n_dly;
        r_tag <= n_tag;
        if (i_cmd.capture) begin
            r_in_delay <= i_delay_ticks;
            r_in_tag   <= i_message_tag;
        end
        if (i_cmd.load_resp) begin
            // zero delay expires at once; anything else here was dropped
            r_out_kind  <= (r_in_delay == '0) ? KIND_EXPIRED : KIND_DROPPED;
            r_out_delay <= r_in_delay;
            r_out_tag   <= r_in_tag;
            r_out_last  <= 1'b1;
        end else if (i_cmd.pop) begin
            r_out_kind  <= KIND_EXPIRED;
            r_out_delay <= r_dly[0];
            r_out_tag   <= r_tag[0];
            r_out_last  <= !next_due;
        end
    end

    always_comb begin
        o_sts               = '0;
        o_sts.in_action     = i_action;
        o_sts.in_delay_zero = (i_delay_ticks == '0);
        o_sts.full          = r_valid[QUEUE_DEPTH-1];
        o_sts.head_due      = head_due;
        o_sts.next_due      = next_due;
        o_sts.out_free      = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_echo_delay  = r_out_delay;
    assign o_echo_tag    = r_out_tag;
    assign o_last_of_run = r_out_last;

    `STQ_ASSERT_IMP(a_valid_prefix, 1'b1, ((r_valid >> 1) & ~r_valid) == '0, "valid cells not a prefix")
    `STQ_ASSERT_IMP(a_insert_room, i_cmd.insert, !r_valid[QUEUE_DEPTH-1] && !i_cmd.pop, "insert into full chain")
    `STQ_ASSERT_IMP(a_pop_due, i_cmd.pop, head_due && out_free, "pop of an entry not due or output busy")
    `STQ_ASSERT_NXT(a_tick_step, i_cmd.tick, r_time == $past(r_time) + 1'b1, "time counter did not advance")

endmodule

>>> hdl/sorted_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Sorted queue of pending alarms with a tick-driven expiry run.
// ----------------------------------------------------------------------------
// Input words (i_in) are either a tick (action 0) or an insert (action 1)
// carrying a delay in ticks and a message tag. Output words (o_out) report an
// expired alarm or an insert dropped because the queue was full; last_of_run
// marks the final word caused by one input word.
// An insert with a nonzero delay into a non-full queue gives no output;
// ready stays high, so such inserts can follow back to back.
// A zero-delay or dropped insert loads one word into the output register from
// the response state once the output is free, ready returning once it is loaded.
// A tick advances the time counter, then the expired entries leave from the
// head of the cell chain at one word per cycle while the output is free;
// ready stays low until the run ends, and also while the controller checks
// the head when nothing is due.
// A stalled receiver holds the output register and pauses the run; the next
// input word is still taken while a finished word waits.
// Reset empties the queue, clears the time counter and the output valid flag.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit
    import stq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    stq_in_if.sink    i_in,
    stq_out_if.source o_out
);

    t_stq_cmd cmd;
    t_stq_sts sts;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_in.action),
        .i_delay_ticks (i_in.delay_ticks),
        .i_message_tag (i_in.message_tag),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_result_kind (o_out.result_kind),
        .o_echo_delay  (o_out.echo_delay),
        .o_echo_tag    (o_out.echo_tag),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_timer_queue_unit. Keeps its own sorted list
// of pending alarms, predicts every expiry and drop word from the accepted
// input words and checks the output words in order, under random idling on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct {
        logic [TIME_W-1:0]  deadline;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } t_alarm;

    typedef struct {
        logic               kind;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } t_alarm_word;

    logic i_clk;
    logic i_rst_n;

    stq_in_if  in_ch ();
    stq_out_if out_ch ();

    sorted_timer_queue_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_alarm          pending_alarms[$];
    t_alarm_word     due_words[$];
    logic [TIME_W-1:0] clock_ticks;
    int              error_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_left;

    always #2 i_clk = ~i_clk;

    // Track the queue contents and queue up the words each input word causes
    function automatic void track_alarms(input logic act, input logic [DELAY_W-1:0] dly,
                                         input logic [TAG_W-1:0] tag);
        t_alarm            a;
        int                pos;
        logic [TIME_W-1:0] remain;
        logic              more;
        if (act == ACT_INSERT) begin
            if (dly == '0) begin
                due_words.push_back(t_alarm_word'{KIND_EXPIRED, dly, tag, 1'b1});
            end else if (pending_alarms.size() >= QUEUE_DEPTH) begin
                due_words.push_back(t_alarm_word'{KIND_DROPPED, dly, tag, 1'b1});
            end else begin
                pos = pending_alarms.size();
                for (int i = 0; i < pending_alarms.size(); i++) begin
                    remain = pending_alarms[i].deadline - clock_ticks;
                    if (remain >= TIME_W'(dly)) begin
                        pos = i;
                        break;
                    end
                end
                a.deadline = clock_ticks + TIME_W'(dly);
                a.delay    = dly;
                a.tag      = tag;
                pending_alarms.insert(pos, a);
            end
        end else begin
            clock_ticks = clock_ticks + 1'b1;
            while (pending_alarms.size() > 0 && pending_alarms[0].deadline == clock_ticks) begin
                a    = pending_alarms.pop_front();
                more = pending_alarms.size() > 0 && pending_alarms[0].deadline == clock_ticks;
                due_words.push_back(t_alarm_word'{KIND_EXPIRED, a.delay, a.tag, !more});
            end
        end
    endfunction

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_word(input logic act, input logic [DELAY_W-1:0] dly,
                             input logic [TAG_W-1:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.delay_ticks <= dly;
        in_ch.message_tag <= tag;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_alarms(act, dly, tag);
    endtask

    task automatic send_tick();
        send_word(ACT_TICK, DELAY_W'($urandom), $urandom);
    endtask

    task automatic test_zero_delay();
        send_word(ACT_INSERT, '0, '0);
        send_word(ACT_INSERT, '0, '1);
    endtask

    // Fill with equal deadlines, overflow, then expire the whole queue in one run
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH; i++) send_word(ACT_INSERT, 16'd2, $urandom);
        send_word(ACT_INSERT, '1, '1);
        send_word(ACT_INSERT, '0, $urandom);
        send_tick();
        send_tick();
    endtask

    // Hold the receiver off while inserts, zero-delay words and a tick keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_left     = 300;
        for (int i = 0; i < 4; i++) send_word(ACT_INSERT, 16'd1, $urandom);
        for (int i = 0; i < 6; i++) send_word(ACT_INSERT, '0, $urandom);
        send_tick();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        int                 pick;
        logic [DELAY_W-1:0] dly;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_tick();
            end else begin
                pick = $urandom_range(0, 99);
                if (pending_alarms.size() >= QUEUE_DEPTH && pick < 50)
                    dly = DELAY_W'($urandom);
                else if (pick < 8)
                    dly = '0;
                else if (pick < 11)
                    dly = DELAY_W'($urandom);
                else
                    dly = DELAY_W'($urandom_range(1, 24));
                send_word(ACT_INSERT, dly, $urandom);
            end
        end
    endtask

    // Receiver: random idling plus an optional counted hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_alarm_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_words.size() == 0) begin
                $display("%0t unexpected word: kind %0d delay %0d tag %h last %0d", $time,
                         out_ch.result_kind, out_ch.echo_delay, out_ch.echo_tag,
                         out_ch.last_of_run);
                error_count++;
            end else begin
                exp_w = due_words.pop_front();
                if (out_ch.result_kind !== exp_w.kind || out_ch.echo_delay !== exp_w.delay ||
                    out_ch.echo_tag !== exp_w.tag || out_ch.last_of_run !== exp_w.last) begin
                    $display("%0t mismatch: expected kind %0d delay %0d tag %h last %0d",
                             $time, exp_w.kind, exp_w.delay, exp_w.tag, exp_w.last);
                    $display("%0t           actual   kind %0d delay %0d tag %h last %0d",
                             $time, out_ch.result_kind, out_ch.echo_delay, out_ch.echo_tag,
                             out_ch.last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_TICK;
        in_ch.delay_ticks <= '0;
        in_ch.message_tag <= '0;
        clock_ticks       = '0;
        error_count       = 0;
        hold_left         = 0;
        send_idle_pct     = 36;
        recv_idle_pct     = 83;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_delay();
        test_full_queue();
        test_backpressure();
        test_random(30, 36, 83);
        test_random(30, 83, 36);
        test_random(30, 0, 0);

        in_ch.valid <= 1'b0;
        recv_idle_pct = 0;
        while (due_words.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
